// ----- design/lsps_pkg.sv -----
package lsps_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int STEER_LIMIT  = 30;
    localparam int DEAD_BAND    = 5;
    localparam int DERIV_PERIOD = 24;
    localparam int INTEG_LIMIT  = 64000;
    localparam int ERR_MAX      = 32767;
    localparam int SPEED_MAX    = 100;

    // ceil(2^23/200) == ceil(2^22/100); exact for the operand ranges used
    localparam int RECIP        = 41944;
    localparam int DIV200_SHIFT = 23;
    localparam int DIV100_SHIFT = 22;

    localparam logic [3:0] REG_REFERENCE_LEVEL = 4'd0;
    localparam logic [3:0] REG_CLAMP_INTERVAL  = 4'd1;
    localparam logic [3:0] REG_ERROR_GAIN      = 4'd2;
    localparam logic [3:0] REG_BASE_SPEED      = 4'd3;

    localparam logic [9:0]  RST_REFERENCE_LEVEL = 10'd555;
    localparam logic [8:0]  RST_CLAMP_INTERVAL  = 9'd41;
    localparam logic [14:0] RST_ERROR_GAIN      = 15'd624;
    localparam logic [6:0]  RST_BASE_SPEED      = 7'd65;

    typedef struct packed {
        logic [9:0]  reference_level;
        logic [8:0]  clamp_interval;
        logic [14:0] error_gain;
        logic [6:0]  base_speed;
    } lsps_cfg_t;

    typedef struct packed {
        logic signed [5:0] steering;
        logic signed [7:0] right_speed;
        logic signed [7:0] left_speed;
        logic              go_right;
    } lsps_result_t;

endpackage

// ----- design/lsps_mul.sv -----
module lsps_mul (
    input  logic [15:0] op_a,
    input  logic [15:0] op_b,
    output logic [31:0] prod
);

    assign prod = 32'(op_a) * 32'(op_b);

endmodule

// ----- design/lsps_core.sv -----
module lsps_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lsps_pkg::lsps_cfg_t         cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0] in_sample,
    output logic                        res_valid,
    input  logic                        res_ready,
    output lsps_pkg::lsps_result_t      res
);

    localparam int DW = ((lsps_pkg::SAMPLE_BITS > 10) ? lsps_pkg::SAMPLE_BITS : 10) + 2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLAMP = 7'b0000010,
        ST_ERR   = 7'b0000100,
        ST_INC   = 7'b0001000,
        ST_SUMA  = 7'b0010000,
        ST_SUMB  = 7'b0100000,
        ST_DIV   = 7'b1000000
    } lsps_state_t;

    localparam logic signed [DW-1:0] DB_S   = DW'(lsps_pkg::DEAD_BAND);
    localparam logic signed [18:0]   ILIM_S = 19'(lsps_pkg::INTEG_LIMIT);
    localparam logic [15:0]          RECIP_U = 16'(lsps_pkg::RECIP);

    function automatic logic signed [7:0] sat_speed(input logic signed [9:0] v);
        logic signed [9:0] lim;
        lim = 10'(lsps_pkg::SPEED_MAX);
        if (v > lim) begin
            return 8'(lim);
        end else if (v < -lim) begin
            return 8'(-lim);
        end
        return v[7:0];
    endfunction

    lsps_state_t state_reg, state_next;

    logic [lsps_pkg::SAMPLE_BITS-1:0] samp_reg, samp_next;
    logic [8:0]         d_mag_reg, d_mag_next;
    logic               d_neg_reg, d_neg_next;
    logic signed [15:0] err_reg, err_next;
    logic [15:0]        err_mag_reg, err_mag_next;
    logic               err_neg_reg, err_neg_next;
    logic               turn_reg, turn_next;
    logic signed [17:0] integ_reg, integ_next;
    logic signed [15:0] held_reg, held_next;
    logic signed [19:0] deriv_reg, deriv_next;
    logic [4:0]         tick_reg, tick_next;
    logic signed [25:0] sum_reg, sum_next;

    logic [15:0] mul_a, mul_b;
    logic [31:0] mul_p;

    logic signed [DW-1:0] d0, d_c, d_m, iv_s;
    logic [7:0]           q_inc;
    logic signed [8:0]    inc_s;
    logic signed [18:0]   acc_s;
    logic signed [16:0]   diff_s;
    logic signed [25:0]   e_x, i_x, d_x;
    logic [25:0]          s_mag;
    logic [17:0]          x_div;
    logic [13:0]          x_sat;
    logic [7:0]           q_div, q_clip;
    logic signed [8:0]    steer_s;
    logic signed [9:0]    base_s;

    lsps_mul u_mul (
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    always_comb begin
        unique case (state_reg)
            ST_ERR: begin
                mul_a = 16'(d_mag_reg);
                mul_b = 16'(cfg.error_gain);
            end
            ST_INC: begin
                mul_a = err_mag_reg;
                mul_b = RECIP_U;
            end
            ST_DIV: begin
                mul_a = 16'(x_sat);
                mul_b = RECIP_U;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // clamp, then dead band
    always_comb begin
        d0   = $signed(DW'(samp_reg)) - $signed(DW'(cfg.reference_level));
        iv_s = $signed(DW'(cfg.clamp_interval));
        if (d0 > iv_s) begin
            d_c = iv_s;
        end else if (d0 < -iv_s) begin
            d_c = -iv_s;
        end else if (d0 < DB_S && d0 > -DB_S) begin
            d_c = '0;
        end else begin
            d_c = d0;
        end
        d_m = d_c[DW-1] ? -d_c : d_c;
    end

    always_comb begin
        q_inc  = mul_p[lsps_pkg::DIV200_SHIFT+7:lsps_pkg::DIV200_SHIFT];
        inc_s  = err_neg_reg ? -$signed({1'b0, q_inc}) : $signed({1'b0, q_inc});
        acc_s  = 19'(integ_reg) + 19'(inc_s);
        diff_s = 17'(err_reg) - 17'(held_reg);
        e_x    = 26'(err_reg);
        i_x    = 26'(integ_reg);
        d_x    = 26'(deriv_reg);
        s_mag  = sum_reg[25] ? 26'(-sum_reg) : 26'(sum_reg);
        x_div  = s_mag[25:8];
        x_sat  = (x_div > 18'h03FFF) ? 14'h3FFF : x_div[13:0];
        q_div  = mul_p[lsps_pkg::DIV100_SHIFT+7:lsps_pkg::DIV100_SHIFT];
        q_clip = (q_div > 8'(lsps_pkg::STEER_LIMIT)) ? 8'(lsps_pkg::STEER_LIMIT) : q_div;
        steer_s = sum_reg[25] ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});
        base_s  = $signed(10'(cfg.base_speed));
    end

    always_comb begin
        state_next   = state_reg;
        samp_next    = samp_reg;
        d_mag_next   = d_mag_reg;
        d_neg_next   = d_neg_reg;
        err_next     = err_reg;
        err_mag_next = err_mag_reg;
        err_neg_next = err_neg_reg;
        turn_next    = turn_reg;
        integ_next   = integ_reg;
        held_next    = held_reg;
        deriv_next   = deriv_reg;
        tick_next    = tick_reg;
        sum_next     = sum_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    samp_next  = in_sample;
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                d_mag_next = d_m[8:0];
                d_neg_next = d_c[DW-1];
                state_next = ST_ERR;
            end
            ST_ERR: begin
                if (!d_neg_reg) begin
                    if (mul_p > 32'(lsps_pkg::ERR_MAX)) begin
                        err_next     = 16'sh7FFF;
                        err_mag_next = 16'h7FFF;
                    end else begin
                        err_next     = $signed(mul_p[15:0]);
                        err_mag_next = mul_p[15:0];
                    end
                end else begin
                    if (mul_p > 32'(lsps_pkg::ERR_MAX + 1)) begin
                        err_next     = 16'sh8000;
                        err_mag_next = 16'h8000;
                    end else begin
                        err_next     = $signed(16'h0000 - mul_p[15:0]);
                        err_mag_next = mul_p[15:0];
                    end
                end
                err_neg_next = d_neg_reg && (mul_p != 32'd0);
                turn_next    = d_neg_reg || (mul_p == 32'd0);
                state_next   = ST_INC;
            end
            ST_INC: begin
                if (tick_reg >= 5'(lsps_pkg::DERIV_PERIOD)) begin
                    deriv_next = 20'(diff_s) <<< 3;
                    held_next  = err_reg;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_reg + 5'd1;
                end
                if (acc_s < ILIM_S && acc_s > -ILIM_S) begin
                    integ_next = acc_s[17:0];
                end
                state_next = ST_SUMA;
            end
            ST_SUMA: begin
                sum_next   = (e_x <<< 3) + (e_x <<< 1) + (i_x <<< 2);
                state_next = ST_SUMB;
            end
            ST_SUMB: begin
                sum_next   = sum_reg + (d_x <<< 4) + (d_x <<< 3) + d_x;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            integ_reg <= '0;
            held_reg  <= '0;
            deriv_reg <= '0;
            tick_reg  <= '0;
        end else begin
            state_reg <= state_next;
            integ_reg <= integ_next;
            held_reg  <= held_next;
            deriv_reg <= deriv_next;
            tick_reg  <= tick_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg    <= samp_next;
        d_mag_reg   <= d_mag_next;
        d_neg_reg   <= d_neg_next;
        err_reg     <= err_next;
        err_mag_reg <= err_mag_next;
        err_neg_reg <= err_neg_next;
        turn_reg    <= turn_next;
        sum_reg     <= sum_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DIV);

    always_comb begin
        res.steering    = steer_s[5:0];
        res.right_speed = sat_speed(base_s + 10'(steer_s));
        res.left_speed  = sat_speed(base_s - 10'(steer_s));
        res.go_right    = turn_reg;
    end

endmodule

// ----- design/light_sensor_pid_steering.sv -----
// Channel   Direction  Handshake              Beat contents
// s_        in         s_valid / s_ready      s_light_sample
// m_        out        m_valid / m_ready      m_steering, m_right_speed, m_left_speed,
//                                             m_go_right
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each sample passes through the accept cycle, clamp, then five sequencer steps (error
// scale, divide by 200, two sum steps, divide by 100) before the next is accepted;
// the scale and both divides share a single 16x16 multiplier.
// Reset (aresetn low, synchronous) restores the register defaults and clears the
// integral, derivative, held error and tick count.
// A result waiting in the output register does not block the next sample; the last
// sequencer step holds until that register is free.
module light_sensor_pid_steering (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]    s_light_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [5:0]                   m_steering,
    output logic signed [7:0]                   m_right_speed,
    output logic signed [7:0]                   m_left_speed,
    output logic                                m_go_right,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [3:0]                          cfg_index,
    input  logic [14:0]                         cfg_data
);

    lsps_pkg::lsps_cfg_t    cfg_reg;
    lsps_pkg::lsps_result_t res;
    lsps_pkg::lsps_result_t out_reg;
    logic                   m_valid_reg;
    logic                   res_valid;
    logic                   res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reference_level <= lsps_pkg::RST_REFERENCE_LEVEL;
            cfg_reg.clamp_interval  <= lsps_pkg::RST_CLAMP_INTERVAL;
            cfg_reg.error_gain      <= lsps_pkg::RST_ERROR_GAIN;
            cfg_reg.base_speed      <= lsps_pkg::RST_BASE_SPEED;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lsps_pkg::REG_REFERENCE_LEVEL: cfg_reg.reference_level <= cfg_data[9:0];
                lsps_pkg::REG_CLAMP_INTERVAL:  cfg_reg.clamp_interval  <= cfg_data[8:0];
                lsps_pkg::REG_ERROR_GAIN:      cfg_reg.error_gain      <= cfg_data;
                lsps_pkg::REG_BASE_SPEED:      cfg_reg.base_speed      <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    lsps_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (s_light_sample),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_steering    = out_reg.steering;
    assign m_right_speed = out_reg.right_speed;
    assign m_left_speed  = out_reg.left_speed;
    assign m_go_right    = out_reg.go_right;

endmodule
